// ===== hw/rtl/btir_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary thinning and island removal: shared definitions
// Geometry limits, field widths, register indexes, pass codes and the
// structures that travel along the chain of pass cells.
// ----------------------------------------------------------------------------
package btir_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_DIM    = 3;
   localparam int NUM_PASSES = 9;

   localparam int FW_BITS  = 11;
   localparam int FH_BITS  = 12;
   localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
   localparam int HGT_BITS = $clog2(MAX_HEIGHT + 1);
   localparam int TOT_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int CNT_BITS = 23;
   localparam int POS_BITS = CNT_BITS + 1;
   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT);

   localparam int RING_DEPTH = MAX_WIDTH;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int RING_BITS  = 2;

   localparam int DATA_BITS = 8;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam int RST_FRAME_WIDTH  = 640;
   localparam int RST_FRAME_HEIGHT = 480;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      PASS_TOP,
      PASS_RIGHT,
      PASS_BOTTOM,
      PASS_LEFT,
      PASS_NE,
      PASS_SE,
      PASS_SW,
      PASS_NW,
      PASS_ISLAND
   } pass_type;

   typedef struct packed {
      logic [WID_BITS-1:0] wid;
      logic [HGT_BITS-1:0] hgt;
      logic [TOT_BITS-1:0] total;
   } geom_type;

   typedef struct packed {
      logic                valid;
      logic                pix;
      logic [POS_BITS-1:0] pos;
   } item_type;

endpackage

// ===== hw/rtl/binary_thinning_island_removal_core.sv =====
// ----------------------------------------------------------------------------
// Binary thinning and island removal core
// Streams a binary image through eight hit-or-miss thinning passes and an
// isolated-pixel pass, one pixel per clock while the receiver keeps up.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ stream in raster order, one per transaction, with
// frame_start in req_tuser on the first pixel of a frame. Each accepted
// transaction yields exactly one rsp_ transaction. The result pixel belongs
// to the frame position 9*(w+1) transactions earlier, w being frame_width
// clamped to 3..1024; rsp_tuser says whether it is a real frame pixel and
// rsp_tlast marks the final one. The host flushes a frame by sending
// filler transactions after it. One transaction is taken per clock while
// the receiver does not stall; the rate is set by the nine pass cells,
// each doing one window update and one read and write of its row ring per
// pixel. An empty stage in the chain never holds back the stages before
// it. When the receiver stalls, the chain fills up and req_tready falls
// once every stage holds a transaction.
// Reset clears the frame position counter and the stage valid flags and
// loads 640 by 480 into the geometry registers. The row rings are not
// cleared; no valid result depends on their power-up contents.
// frame_width is at byte address 0 and frame_height at byte address 4.
// ----------------------------------------------------------------------------
module binary_thinning_island_removal_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [btir_pkg::DATA_BITS-1:0]   req_tdata,   // [0] pixel_in, rest zero
   input  logic                             req_tuser,   // [0] frame_start
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [btir_pkg::DATA_BITS-1:0]   rsp_tdata,   // [0] pixel_out, rest zero
   output logic                             rsp_tuser,   // [0] out_valid
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [btir_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [btir_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [btir_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                             csr_pready
);
   import btir_pkg::*;

   function automatic logic [WID_BITS-1:0] clamp_width(input logic [FW_BITS-1:0] v);
      logic [WID_BITS-1:0] r;
      if (int'(v) < MIN_DIM) begin
         r = WID_BITS'(MIN_DIM);
      end else if (int'(v) > MAX_WIDTH) begin
         r = WID_BITS'(MAX_WIDTH);
      end else begin
         r = WID_BITS'(v);
      end
      return r;
   endfunction

   function automatic logic [HGT_BITS-1:0] clamp_height(input logic [FH_BITS-1:0] v);
      logic [HGT_BITS-1:0] r;
      if (int'(v) < MIN_DIM) begin
         r = HGT_BITS'(MIN_DIM);
      end else if (int'(v) > MAX_HEIGHT) begin
         r = HGT_BITS'(MAX_HEIGHT);
      end else begin
         r = HGT_BITS'(v);
      end
      return r;
   endfunction

   logic                csr_write;
   logic                csr_sel_height;
   logic [FW_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [FH_BITS-1:0]  frame_height_ff, frame_height_in;
   logic [WID_BITS-1:0] wid_ff, wid_in;
   logic [HGT_BITS-1:0] hgt_ff, hgt_in;
   logic [TOT_BITS-1:0] total_ff, total_in;
   geom_type            geom;

   logic                req_accept;
   logic [CNT_BITS-1:0] item_cnt_ff, item_cnt_in;
   logic [CNT_BITS-1:0] t_cur;
   item_type            entry_ff, entry_in;
   item_type            link [NUM_PASSES:0];
   logic [NUM_PASSES+1:0] ld;

   logic                 out_range;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                 rsp_tuser_ff, rsp_tuser_in;
   logic                 rsp_tlast_ff, rsp_tlast_in;

   // Configuration registers.
   assign csr_pready     = 1'b1;
   assign csr_write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel_height = (csr_paddr[CSR_AW-1] == REG_FRAME_HEIGHT);

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      wid_in          = wid_ff;
      hgt_in          = hgt_ff;
      total_in        = total_ff;
      if (csr_write) begin
         if (csr_sel_height) begin
            frame_height_in = csr_pwdata[FH_BITS-1:0];
            hgt_in          = clamp_height(csr_pwdata[FH_BITS-1:0]);
            total_in        = TOT_BITS'(wid_ff) * TOT_BITS'(hgt_in);
         end else begin
            frame_width_in = csr_pwdata[FW_BITS-1:0];
            wid_in         = clamp_width(csr_pwdata[FW_BITS-1:0]);
            total_in       = TOT_BITS'(wid_in) * TOT_BITS'(hgt_ff);
         end
      end
   end

   assign csr_prdata = csr_sel_height ? CSR_DW'(frame_height_ff) : CSR_DW'(frame_width_ff);

   always_comb begin
      geom.wid   = wid_ff;
      geom.hgt   = hgt_ff;
      geom.total = total_ff;
   end

   // Stage loads: a stage takes new contents when it is empty or drains.
   always_comb begin
      ld[NUM_PASSES+1] = !rsp_tvalid_ff || rsp_tready;
      for (int i = NUM_PASSES; i >= 0; i--) begin
         ld[i] = !link[i].valid || ld[i+1];
      end
   end

   assign req_tready = ld[0];
   assign req_accept = req_tvalid && req_tready;

   // Entry stage: frame position and filler masking.
   always_comb begin
      t_cur       = req_tuser ? '0 : item_cnt_ff;
      item_cnt_in = item_cnt_ff;
      if (req_accept) begin
         item_cnt_in = (t_cur == '1) ? t_cur : t_cur + CNT_BITS'(1);
      end
      entry_in = entry_ff;
      if (ld[0]) begin
         entry_in.valid = req_tvalid;
         entry_in.pix   = req_tdata[0] && (t_cur < CNT_BITS'(total_ff));
         entry_in.pos   = POS_BITS'(t_cur);
      end
   end

   assign link[0] = entry_ff;

   for (genvar i = 0; i < NUM_PASSES; i++) begin : g_pass
      btir_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .pass_sel (pass_type'(i)),
         .geom     (geom),
         .load     (ld[i+1]),
         .up       (link[i]),
         .dn       (link[i+1])
      );
   end

   // Output register.
   always_comb begin
      out_range = !link[NUM_PASSES].pos[POS_BITS-1]
                && (link[NUM_PASSES].pos[CNT_BITS-1:0] < CNT_BITS'(total_ff));
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (ld[NUM_PASSES+1]) begin
         rsp_tvalid_in = link[NUM_PASSES].valid;
         rsp_tdata_in  = DATA_BITS'(out_range && link[NUM_PASSES].pix);
         rsp_tuser_in  = out_range;
         rsp_tlast_in  = out_range && (link[NUM_PASSES].pos[CNT_BITS-1:0]
                       == (CNT_BITS'(total_ff) - CNT_BITS'(1)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW_BITS'(RST_FRAME_WIDTH);
         frame_height_ff <= FH_BITS'(RST_FRAME_HEIGHT);
         wid_ff          <= WID_BITS'(RST_FRAME_WIDTH);
         hgt_ff          <= HGT_BITS'(RST_FRAME_HEIGHT);
         total_ff        <= TOT_BITS'(RST_FRAME_WIDTH * RST_FRAME_HEIGHT);
         item_cnt_ff     <= '0;
         entry_ff.valid  <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         wid_ff          <= wid_in;
         hgt_ff          <= hgt_in;
         total_ff        <= total_in;
         item_cnt_ff     <= item_cnt_in;
         entry_ff        <= entry_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // The input side only stalls when the whole chain is full behind a
   // stalled result.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while the output side could drain");

   // A frame start restarts the frame position at the first pixel.
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser) |=> (item_cnt_ff == CNT_BITS'(1)))
      else $error("frame position did not restart on frame start");

   // The last pixel of a frame is always a real frame pixel.
   a_last_is_real: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("frame end flagged on a pixel outside the frame");

   // Positions outside the frame carry a cleared pixel.
   a_outside_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("pixel set on a position outside the frame");

endmodule

// ===== hw/rtl/btir_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btir_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/btir_cell.sv =====
// ----------------------------------------------------------------------------
// Binary thinning and island removal: one pass cell
// Holds the 3x3 window of one pass, with a one-row ring of raw and
// processed pixels, and hands each processed pixel to the next cell.
// ----------------------------------------------------------------------------
module btir_cell (
   input  logic               clock,
   input  logic               reset,
   input  btir_pkg::pass_type pass_sel,
   input  btir_pkg::geom_type geom,
   input  logic               load,
   input  btir_pkg::item_type up,
   output btir_pkg::item_type dn
);
   import btir_pkg::*;

   typedef struct packed {
      logic a1;
      logic a2;
      logic a3;
      logic b1;
      logic b3;
      logic c1;
      logic c2;
      logic c3;
   } nbr_type;

   function automatic logic pattern_hit(input pass_type p, input nbr_type n);
      logic hit;
      unique case (p)
         PASS_TOP:    hit = !n.a1 && !n.a2 && !n.a3 && n.c1 && n.c2 && n.c3;
         PASS_RIGHT:  hit = !n.a3 && !n.b3 && !n.c3 && n.a1 && n.b1 && n.c1;
         PASS_BOTTOM: hit = !n.c1 && !n.c2 && !n.c3 && n.a1 && n.a2 && n.a3;
         PASS_LEFT:   hit = !n.a1 && !n.b1 && !n.c1 && n.a3 && n.b3 && n.c3;
         PASS_NE:     hit = !n.a2 && !n.a3 && !n.b3 && n.b1 && n.c2;
         PASS_SE:     hit = !n.b3 && !n.c3 && !n.c2 && n.b1 && n.a2;
         PASS_SW:     hit = !n.c2 && !n.c1 && !n.b1 && n.a2 && n.b3;
         PASS_NW:     hit = !n.b1 && !n.a1 && !n.a2 && n.c2 && n.b3;
         PASS_ISLAND: hit = (n == '0);
         default:     hit = 1'b0;
      endcase
      return hit;
   endfunction

   logic                take;
   logic [POS_BITS-1:0] c_pos;
   logic                in_frame;
   logic                at_start;
   logic [COL_BITS-1:0] cur_col;
   logic [ROW_BITS-1:0] cur_row;
   logic [WID_BITS-1:0] col_p1;
   logic                interior;
   nbr_type             nbr;
   logic                y_pix;

   logic [RING_AW-1:0]   ptr_ff, ptr_in;
   logic [RING_BITS-1:0] rd_data;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic x1_ff, x1_in, x2_ff, x2_in, xw1_ff, xw1_in;
   logic y1_ff, y1_in, yw_ff, yw_in, yw1_ff, yw1_in;
   item_type dn_ff, dn_in;

   assign take = load && up.valid;

   always_comb begin
      c_pos    = up.pos - (POS_BITS'(geom.wid) + POS_BITS'(1));
      in_frame = !c_pos[POS_BITS-1] && (c_pos[CNT_BITS-1:0] < CNT_BITS'(geom.total));
      at_start = (c_pos == '0);
      cur_col  = at_start ? '0 : col_ff;
      cur_row  = at_start ? '0 : row_ff;
      col_p1   = WID_BITS'(cur_col) + WID_BITS'(1);
      interior = (cur_col != '0) && (col_p1 < geom.wid) && (cur_row != '0)
               && ((HGT_BITS'(cur_row) + HGT_BITS'(1)) < geom.hgt);

      nbr.a1 = yw1_ff;
      nbr.a2 = yw_ff;
      nbr.a3 = rd_data[0];
      nbr.b1 = y1_ff;
      nbr.b3 = rd_data[1];
      nbr.c1 = x2_ff;
      nbr.c2 = x1_ff;
      nbr.c3 = up.pix;

      y_pix = xw1_ff && !(in_frame && interior && pattern_hit(pass_sel, nbr));
   end

   always_comb begin
      ptr_in = ptr_ff;
      col_in = col_ff;
      row_in = row_ff;
      x1_in  = x1_ff;
      x2_in  = x2_ff;
      xw1_in = xw1_ff;
      y1_in  = y1_ff;
      yw_in  = yw_ff;
      yw1_in = yw1_ff;
      if (take) begin
         if ((WID_BITS'(ptr_ff) + WID_BITS'(2)) >= geom.wid) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + RING_AW'(1);
         end
         if (col_p1 == geom.wid) begin
            col_in = '0;
            row_in = cur_row + ROW_BITS'(1);
         end else begin
            col_in = COL_BITS'(col_p1);
            row_in = cur_row;
         end
         x1_in  = up.pix;
         x2_in  = x1_ff;
         xw1_in = rd_data[1];
         y1_in  = y_pix;
         yw_in  = rd_data[0];
         yw1_in = yw_ff;
      end
   end

   always_comb begin
      dn_in = dn_ff;
      if (load) begin
         dn_in.valid = up.valid;
         dn_in.pix   = y_pix;
         dn_in.pos   = c_pos;
      end
   end

   btir_ram #(
      .WIDTH (RING_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (take),
      .wr_addr (ptr_ff),
      .wr_data ({x1_ff, y_pix}),
      .rd_addr (ptr_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         dn_ff.valid  <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         col_ff <= col_in;
         row_ff <= row_in;
         dn_ff  <= dn_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff  <= x1_in;
      x2_ff  <= x2_in;
      xw1_ff <= xw1_in;
      y1_ff  <= y1_in;
      yw_ff  <= yw_in;
      yw1_ff <= yw1_in;
   end

   assign dn = dn_ff;

endmodule
